>>> design/qfmx_pkg.sv
// Package for the quadraphonic FM multiplex encoder.
// Holds sizes, register indexes, reset values, the FIR tap ROM and shared types.
// No dependencies.
package qfmx_pkg;

  // Sizes of the datapath.
  localparam int TAP_COUNT      = 32;
  localparam int SAMPLE_BITS    = 24;
  localparam int PHASE_BITS     = 32;
  localparam int SINE_ADDR_BITS = 10;
  localparam int LANES          = 4;
  localparam int ROM_LEN        = 32;
  localparam int ROM_IDX_W      = $clog2(ROM_LEN);
  localparam int COEF_W         = 18;
  localparam int EMPH_W         = SAMPLE_BITS + 4;
  localparam int PTR_W          = $clog2(TAP_COUNT);
  localparam int CNT_W          = $clog2(TAP_COUNT + 1);
  localparam int INQ_DEPTH      = 2;
  localparam int OUTQ_DEPTH     = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int GAIN_W     = 16;
  localparam int CLIP_W     = 23;
  localparam int STEP_W     = 32;

  // Register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA = 3'd0,
    REG_STEP  = 3'd1,
    REG_CLIP  = 3'd2,
    REG_MONO  = 3'd3,
    REG_PILOT = 3'd4,
    REG_S38   = 3'd5,
    REG_C38   = 3'd6,
    REG_S76   = 3'd7
  } cfg_reg_e;

  // Reset values of the registers.
  localparam logic [GAIN_W-1:0] ALPHA_RST = 16'd59053;
  localparam logic [STEP_W-1:0] STEP_RST  = 32'd425022805;
  localparam logic [CLIP_W-1:0] CLIP_RST  = 23'd3565158;
  localparam logic [GAIN_W-1:0] MONO_RST  = 16'd29491;
  localparam logic [GAIN_W-1:0] PILOT_RST = 16'd1475;
  localparam logic [GAIN_W-1:0] S38_RST   = 16'd22938;
  localparam logic [GAIN_W-1:0] C38_RST   = 16'd22938;
  localparam logic [GAIN_W-1:0] S76_RST   = 16'd22938;

  // Quarter-wave polynomial coefficients.
  localparam logic [23:0] POLY_A = 24'd13176794;
  localparam logic [23:0] POLY_B = 24'd5418739;
  localparam logic [23:0] POLY_C = 24'd630552;

  // Windowed-sinc low-pass taps, Q1.17, entry 0 meets the oldest sample.
  localparam logic signed [COEF_W-1:0] COEF_ROM [ROM_LEN] = '{
    -18'sd2, 18'sd2, -18'sd3, 18'sd4, -18'sd6, 18'sd8, -18'sd12, 18'sd16,
    -18'sd22, 18'sd29, -18'sd38, 18'sd51, -18'sd69, 18'sd98, -18'sd154, 18'sd319,
    18'sd20275, -18'sd309, 18'sd151, -18'sd97, 18'sd68, -18'sd50, 18'sd38, -18'sd28,
    18'sd21, -18'sd16, 18'sd11, -18'sd8, 18'sd6, -18'sd4, 18'sd3, -18'sd2
  };

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [GAIN_W-1:0] alpha;
    logic [STEP_W-1:0] step;
    logic [CLIP_W-1:0] clip;
    logic [GAIN_W-1:0] mono;
    logic [GAIN_W-1:0] pilot;
    logic [GAIN_W-1:0] s38;
    logic [GAIN_W-1:0] c38;
    logic [GAIN_W-1:0] s76;
  } cfg_t;

  // One queued request: four samples and the carrier phase that goes with it.
  typedef struct packed {
    logic [LANES-1:0][SAMPLE_BITS-1:0] smp;
    logic [PHASE_BITS-1:0]             phase;
  } item_t;

  // Sequencer of the processing engine.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_TAPS,
    BK_EMPH1,
    BK_EMPH2,
    BK_MIX1,
    BK_MIX2,
    BK_MIX3
  } back_state_e;

  // Tap weight for a position; positions past the ROM weigh zero.
  function automatic logic signed [COEF_W-1:0] coef_at(input logic [CNT_W-1:0] idx);
    logic [31:0]               wide;
    logic signed [COEF_W-1:0] res;
    wide = 32'(idx);
    res  = '0;
    if (wide < 32'(ROM_LEN)) begin
      res = COEF_ROM[wide[ROM_IDX_W-1:0]];
    end
    return res;
  endfunction

endpackage

>>> design/qfmx_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module qfmx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> design/qfmx_front.sv
// Input side of the encoder: accepts requests, tags each with its carrier phase
// and holds them in a short queue for the engine. Depends on qfmx_pkg.
module qfmx_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  output logic                              full_o,
  input  logic [qfmx_pkg::LANES-1:0][qfmx_pkg::SAMPLE_BITS-1:0] smp_i,
  input  logic [qfmx_pkg::STEP_W-1:0]       step_i,
  input  logic                              pop_i,
  output logic                              empty_o,
  output qfmx_pkg::item_t                   head_o
);
  import qfmx_pkg::*;

  localparam int AW = $clog2(INQ_DEPTH);

  logic [PHASE_BITS-1:0] phase_q;
  item_t                 mem_q [INQ_DEPTH];
  logic [AW-1:0]         wr_q, rd_q;
  logic [AW:0]           cnt_q;
  logic                  acc_req, pop_req;

  assign full_o  = (cnt_q == (AW+1)'(INQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign acc_req = push_i && !full_o;
  assign pop_req = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  // Carrier phase advances once per accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (acc_req) begin
      phase_q <= phase_q + PHASE_BITS'(step_i);
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (acc_req) begin
        wr_q <= (wr_q == AW'(INQ_DEPTH-1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_req) begin
        rd_q <= (rd_q == AW'(INQ_DEPTH-1)) ? '0 : rd_q + 1'b1;
      end
      if (acc_req && !pop_req) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_req && !acc_req) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (acc_req) begin
      mem_q[wr_q].smp   <= smp_i;
      mem_q[wr_q].phase <= phase_q;
    end
  end

endmodule

>>> design/qfmx_back.sv
// Processing engine: per-lane FIR over the sample history, emphasis, clipping,
// carrier synthesis and the final mix. Depends on qfmx_pkg and qfmx_ram.
module qfmx_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  qfmx_pkg::cfg_t         cfg_i,
  input  logic                   inq_empty_i,
  input  qfmx_pkg::item_t        head_i,
  output logic                   inq_pop_o,
  input  logic                   outq_full_i,
  output logic                   outq_push_o,
  output logic [qfmx_pkg::SAMPLE_BITS-1:0] mpx_o
);
  import qfmx_pkg::*;

  localparam int SW      = SAMPLE_BITS;
  localparam int PROD_W  = SW + COEF_W;
  localparam int ACC_W   = PROD_W + PTR_W;
  localparam int SIX_W   = ACC_W + 3;
  localparam int F_W     = SIX_W - 17;
  localparam int PA_W    = EMPH_W + GAIN_W + 1;
  localparam int PR_W    = PA_W - 16;
  localparam int DIFF_W  = ((F_W > PR_W) ? F_W : PR_W) + 1;
  localparam int V_W     = EMPH_W + 1;
  localparam int CH_W    = CLIP_W + 1;
  localparam int SUM_W   = CH_W + 2;
  localparam int X_W     = 17;
  localparam int I_W     = 24;
  localparam int SIN_W   = 25;
  localparam int CP_W    = SUM_W + SIN_W;
  localparam int MIX_W   = 64;
  localparam int OFF_W   = SINE_ADDR_BITS - 2;
  localparam int PIL_UP  = (SW >= 24) ? SW - 22 : 0;
  localparam int PIL_DN  = (SW < 24) ? 24 - SW : 0;
  localparam longint PIL_RND = (PIL_DN > 0) ? (longint'(1) << (PIL_DN - 1)) : 0;
  localparam longint EM_HI   = (longint'(1) << (EMPH_W - 1)) - 1;
  localparam longint OUT_HI  = (longint'(1) << (SW - 1)) - 1;

  back_state_e state_q, state_d;

  // FIR sequencing.
  logic [PTR_W-1:0]          ptr_q, rd_addr_q, ptr_nxt, rd_nxt;
  logic [CNT_W-1:0]          cnt_q;
  logic [TAP_COUNT-1:0]      hvld_q;
  logic                      rd_vld_q, iss_q, prod_vld_q;
  logic signed [COEF_W-1:0]  coef_q;
  logic [LANES*SW-1:0]       ram_rdata;
  logic                      ram_we, issue, taps_done;
  logic signed [PROD_W-1:0]  prod_q [LANES];
  logic signed [ACC_W-1:0]   acc_q  [LANES];

  // Emphasis and clipping.
  logic signed [F_W-1:0]     f_q   [LANES];
  logic signed [PA_W-1:0]    pa_q  [LANES];
  logic signed [EMPH_W-1:0]  em_q  [LANES];
  logic signed [CH_W-1:0]    ch_q  [LANES];
  logic signed [SIX_W-1:0]   s6    [LANES];
  logic signed [PA_W-1:0]    pa_r  [LANES];
  logic signed [DIFF_W-1:0]  diff  [LANES];
  logic signed [EMPH_W-1:0]  e_sat [LANES];
  logic signed [V_W-1:0]     v_raw [LANES];
  logic signed [CH_W-1:0]    v_clp [LANES];
  logic signed [V_W-1:0]     lim;

  // Carrier synthesis.
  logic [PHASE_BITS-1:0]     ang   [LANES];
  logic [SINE_ADDR_BITS-1:0] top   [LANES];
  logic [X_W-1:0]            x_in  [LANES];
  logic [X_W-1:0]            x_q   [LANES];
  logic                      neg_q [LANES];
  logic [X_W-1:0]            x2_q  [LANES];
  logic [I_W-1:0]            i1_q  [LANES];
  logic [I_W-1:0]            i2_q  [LANES];
  logic signed [SIN_W-1:0]   sin_q [LANES];
  logic [2*X_W-1:0]          xx    [LANES];
  logic [X_W+I_W-1:0]        x2c   [LANES];
  logic [X_W+I_W-1:0]        x2i   [LANES];
  logic [X_W+I_W-1:0]        xi    [LANES];

  // Mix.
  logic signed [SUM_W-1:0]   sm, d38, dc38, d76;
  logic signed [SIN_W-1:0]   car [3];
  logic signed [SUM_W-1:0]   dif [3];
  logic [GAIN_W-1:0]         cg  [3];
  logic signed [MIX_W-1:0]   mono_q, pil_q;
  logic signed [CP_W-1:0]    cp_q   [3];
  logic signed [MIX_W-1:0]   term_q [3];
  logic signed [CP_W-1:0]    cp_r   [3];
  logic signed [MIX_W-1:0]   pil_term, total, rnd;
  logic [SW-1:0]             mpx_d;

  assign ptr_nxt = (ptr_q == PTR_W'(TAP_COUNT - 1)) ? '0 : ptr_q + 1'b1;
  assign rd_nxt  = (rd_addr_q == PTR_W'(TAP_COUNT - 1)) ? '0 : rd_addr_q + 1'b1;

  // Sample history, one row holds all four lanes.
  qfmx_ram #(
    .WIDTH(LANES * SW),
    .DEPTH(TAP_COUNT)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ptr_q),
    .wdata_i(head_i.smp),
    .raddr_i(rd_addr_q),
    .rdata_o(ram_rdata)
  );

  // Sequencer outputs.
  always_comb begin
    ram_we      = (state_q == BK_LOAD);
    inq_pop_o   = (state_q == BK_LOAD);
    issue       = (state_q == BK_TAPS) && (cnt_q < CNT_W'(TAP_COUNT));
    taps_done   = (state_q == BK_TAPS) && (cnt_q == CNT_W'(TAP_COUNT)) &&
                  !iss_q && !prod_vld_q;
    outq_push_o = (state_q == BK_MIX3) && !outq_full_i;
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:  if (!inq_empty_i) state_d = BK_LOAD;
      BK_LOAD:  state_d = BK_TAPS;
      BK_TAPS:  if (taps_done) state_d = BK_EMPH1;
      BK_EMPH1: state_d = BK_EMPH2;
      BK_EMPH2: state_d = BK_MIX1;
      BK_MIX1:  state_d = BK_MIX2;
      BK_MIX2:  state_d = BK_MIX3;
      BK_MIX3:  if (!outq_full_i) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  // Control registers: state, pointers, history valid bits, emphasis memory.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      ptr_q      <= '0;
      rd_addr_q  <= '0;
      cnt_q      <= '0;
      hvld_q     <= '0;
      iss_q      <= 1'b0;
      prod_vld_q <= 1'b0;
      for (int c = 0; c < LANES; c++) begin
        em_q[c] <= '0;
      end
    end else begin
      state_q    <= state_d;
      iss_q      <= issue;
      prod_vld_q <= iss_q;
      if (state_q == BK_LOAD) begin
        hvld_q[ptr_q] <= 1'b1;
        ptr_q         <= ptr_nxt;
        rd_addr_q     <= ptr_nxt;
        cnt_q         <= '0;
      end
      if (issue) begin
        cnt_q     <= cnt_q + 1'b1;
        rd_addr_q <= rd_nxt;
      end
      if (state_q == BK_EMPH2) begin
        for (int c = 0; c < LANES; c++) begin
          em_q[c] <= e_sat[c];
        end
      end
    end
  end

  // FIR datapath: read, multiply, accumulate.
  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_vld_q <= hvld_q[rd_addr_q];
      coef_q   <= coef_at(cnt_q);
    end
    for (int c = 0; c < LANES; c++) begin
      if (rd_vld_q) begin
        prod_q[c] <= PROD_W'($signed(ram_rdata[c*SW +: SW])) * PROD_W'(coef_q);
      end else begin
        prod_q[c] <= '0;
      end
      if (state_q == BK_LOAD) begin
        acc_q[c] <= '0;
      end else if (prod_vld_q) begin
        acc_q[c] <= acc_q[c] + ACC_W'(prod_q[c]);
      end
    end
  end

  // Emphasis and clip arithmetic.
  always_comb begin
    lim = V_W'($signed({1'b0, cfg_i.clip}));
    for (int c = 0; c < LANES; c++) begin
      s6[c]   = SIX_W'(acc_q[c]) * SIX_W'(6) + SIX_W'(65536);
      pa_r[c] = pa_q[c] + PA_W'(32768);
      diff[c] = DIFF_W'(f_q[c]) - DIFF_W'($signed(pa_r[c][PA_W-1:16]));
      if (diff[c] > DIFF_W'(EM_HI)) begin
        e_sat[c] = EMPH_W'(EM_HI);
      end else if (diff[c] < DIFF_W'(-EM_HI - 1)) begin
        e_sat[c] = EMPH_W'(-EM_HI - 1);
      end else begin
        e_sat[c] = EMPH_W'(diff[c]);
      end
      v_raw[c] = V_W'(e_sat[c]) <<< 1;
      if (v_raw[c] > lim) begin
        v_clp[c] = CH_W'(lim);
      end else if (v_raw[c] < -lim) begin
        v_clp[c] = CH_W'(-lim);
      end else begin
        v_clp[c] = CH_W'(v_raw[c]);
      end
    end
  end

  // Emphasis registers.
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < LANES; c++) begin
      if (state_q == BK_EMPH1) begin
        f_q[c]  <= $signed(s6[c][SIX_W-1:17]);
        pa_q[c] <= PA_W'($signed({1'b0, cfg_i.alpha})) * PA_W'(em_q[c]);
      end
      if (state_q == BK_EMPH2) begin
        ch_q[c] <= v_clp[c];
      end
    end
  end

  // Carrier angles: pilot, twice, twice plus a quarter turn, four times.
  always_comb begin
    ang[0] = head_i.phase;
    ang[1] = head_i.phase << 1;
    ang[2] = (head_i.phase << 1) + (PHASE_BITS'(1) << (PHASE_BITS - 2));
    ang[3] = head_i.phase << 2;
    for (int k = 0; k < LANES; k++) begin
      top[k]  = ang[k][PHASE_BITS-1 -: SINE_ADDR_BITS];
      x_in[k] = X_W'(top[k][OFF_W-1:0]) << (16 - OFF_W);
      if (top[k][SINE_ADDR_BITS-2]) begin
        x_in[k] = X_W'(65536) - x_in[k];
      end
      xx[k]  = (2*X_W)'(x_q[k]) * (2*X_W)'(x_q[k]);
      x2c[k] = (X_W+I_W)'(x2_q[k]) * (X_W+I_W)'(POLY_C);
      x2i[k] = (X_W+I_W)'(x2_q[k]) * (X_W+I_W)'(i1_q[k]);
      xi[k]  = (X_W+I_W)'(x_q[k]) * (X_W+I_W)'(i2_q[k]);
    end
  end

  // Quarter-wave polynomial; the stages settle while the FIR runs.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < LANES; k++) begin
      if (state_q == BK_LOAD) begin
        x_q[k]   <= x_in[k];
        neg_q[k] <= top[k][SINE_ADDR_BITS-1];
      end
      x2_q[k] <= X_W'(xx[k] >> 16);
      i1_q[k] <= POLY_B - I_W'(x2c[k] >> 16);
      i2_q[k] <= POLY_A - I_W'(x2i[k] >> 16);
      if (neg_q[k]) begin
        sin_q[k] <= -$signed(SIN_W'(xi[k] >> 16));
      end else begin
        sin_q[k] <= $signed(SIN_W'(xi[k] >> 16));
      end
    end
  end

  // Sum and difference matrices, carriers and their gains.
  always_comb begin
    sm     = SUM_W'(ch_q[0]) + SUM_W'(ch_q[1]) + SUM_W'(ch_q[2]) + SUM_W'(ch_q[3]);
    d38    = SUM_W'(ch_q[0]) + SUM_W'(ch_q[2]) - SUM_W'(ch_q[1]) - SUM_W'(ch_q[3]);
    dc38   = SUM_W'(ch_q[0]) + SUM_W'(ch_q[3]) - SUM_W'(ch_q[2]) - SUM_W'(ch_q[1]);
    d76    = SUM_W'(ch_q[0]) + SUM_W'(ch_q[1]) - SUM_W'(ch_q[2]) - SUM_W'(ch_q[3]);
    dif[0] = d38;
    dif[1] = dc38;
    dif[2] = d76;
    car[0] = -sin_q[1];
    car[1] = -sin_q[2];
    car[2] = sin_q[3];
    cg[0]  = cfg_i.s38;
    cg[1]  = cfg_i.c38;
    cg[2]  = cfg_i.s76;
    for (int k = 0; k < 3; k++) begin
      cp_r[k] = cp_q[k] + CP_W'(longint'(1) << 22);
    end
  end

  // Mix products.
  always_ff @(posedge clk_i) begin
    if (state_q == BK_MIX1) begin
      mono_q <= MIX_W'(sm) * MIX_W'($signed({1'b0, cfg_i.mono}));
      pil_q  <= MIX_W'(sin_q[0]) * MIX_W'($signed({1'b0, cfg_i.pilot}));
      for (int k = 0; k < 3; k++) begin
        cp_q[k] <= CP_W'(dif[k]) * CP_W'(car[k]);
      end
    end
    if (state_q == BK_MIX2) begin
      for (int k = 0; k < 3; k++) begin
        term_q[k] <= MIX_W'($signed(cp_r[k][CP_W-1:23])) *
                     MIX_W'($signed({1'b0, cg[k]}));
      end
    end
  end

  // Final sum, rounding and saturation.
  always_comb begin
    if (PIL_DN == 0) begin
      pil_term = pil_q <<< PIL_UP;
    end else begin
      pil_term = ((pil_q <<< 2) + MIX_W'(PIL_RND)) >>> PIL_DN;
    end
    total = mono_q + pil_term + term_q[0] + term_q[1] + term_q[2];
    rnd   = (total + MIX_W'(131072)) >>> 18;
    if (rnd > MIX_W'(OUT_HI)) begin
      mpx_d = SW'(OUT_HI);
    end else if (rnd < MIX_W'(-OUT_HI - 1)) begin
      mpx_d = SW'(-OUT_HI - 1);
    end else begin
      mpx_d = SW'(rnd);
    end
  end

  assign mpx_o = mpx_d;

endmodule

>>> design/qfmx_outq.sv
// Result queue between the engine and the output port.
// Depends on qfmx_pkg.
module qfmx_outq (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  logic [qfmx_pkg::SAMPLE_BITS-1:0] data_i,
  output logic                             full_o,
  input  logic                             pop_i,
  output logic                             empty_o,
  output logic [qfmx_pkg::SAMPLE_BITS-1:0] data_o
);
  import qfmx_pkg::*;

  localparam int AW = $clog2(OUTQ_DEPTH);

  logic [SAMPLE_BITS-1:0] mem_q [OUTQ_DEPTH];
  logic [AW-1:0]          wr_q, rd_q;
  logic [AW:0]            cnt_q;
  logic                   wr_en, rd_en;

  assign full_o  = (cnt_q == (AW+1)'(OUTQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) begin
        wr_q <= (wr_q == AW'(OUTQ_DEPTH-1)) ? '0 : wr_q + 1'b1;
      end
      if (rd_en) begin
        rd_q <= (rd_q == AW'(OUTQ_DEPTH-1)) ? '0 : rd_q + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

>>> design/quadraphonic_fm_multiplex_encoder_core.sv
// Top level of the quadraphonic FM multiplex encoder: register file and the
// front, engine and result queue. Depends on qfmx_pkg, qfmx_front, qfmx_back, qfmx_outq.
//
//  Channel   Signals                                    Direction
//  input     push, full, front/rear left/right _i       in (queue write side)
//  result    pop, empty, mpx_sample_o                   out (queue read side)
//  config    cfg_we_i, cfg_idx_i, cfg_data_i            in (write only)
//
// In the engine the FIR walks the history memory one row per cycle; the engine
// takes the next request only after it has pushed the last result.
// Two requests can wait in the input queue and two results in the result queue.
// Reset is asynchronous and clears the history, emphasis state and carrier phase.
// A full result queue holds the engine; the input queue keeps taking requests.
module quadraphonic_fm_multiplex_encoder_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [qfmx_pkg::SAMPLE_BITS-1:0] front_left_i,
  input  logic signed [qfmx_pkg::SAMPLE_BITS-1:0] front_right_i,
  input  logic signed [qfmx_pkg::SAMPLE_BITS-1:0] rear_left_i,
  input  logic signed [qfmx_pkg::SAMPLE_BITS-1:0] rear_right_i,
  input  logic                                  pop,
  output logic                                  empty,
  output logic signed [qfmx_pkg::SAMPLE_BITS-1:0] mpx_sample_o,
  input  logic                                  cfg_we_i,
  input  logic [qfmx_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [qfmx_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import qfmx_pkg::*;

  cfg_t                              cfg_q;
  item_t                             head;
  logic [LANES-1:0][SAMPLE_BITS-1:0] smp;
  logic                              inq_empty, inq_pop, outq_full, outq_push;
  logic [SAMPLE_BITS-1:0]            mpx_res, mpx_out;

  assign smp[0] = front_left_i;
  assign smp[1] = front_right_i;
  assign smp[2] = rear_left_i;
  assign smp[3] = rear_right_i;
  assign mpx_sample_o = $signed(mpx_out);

  // Register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha <= ALPHA_RST;
      cfg_q.step  <= STEP_RST;
      cfg_q.clip  <= CLIP_RST;
      cfg_q.mono  <= MONO_RST;
      cfg_q.pilot <= PILOT_RST;
      cfg_q.s38   <= S38_RST;
      cfg_q.c38   <= C38_RST;
      cfg_q.s76   <= S76_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ALPHA: cfg_q.alpha <= cfg_data_i[GAIN_W-1:0];
        REG_STEP:  cfg_q.step  <= cfg_data_i[STEP_W-1:0];
        REG_CLIP:  cfg_q.clip  <= cfg_data_i[CLIP_W-1:0];
        REG_MONO:  cfg_q.mono  <= cfg_data_i[GAIN_W-1:0];
        REG_PILOT: cfg_q.pilot <= cfg_data_i[GAIN_W-1:0];
        REG_S38:   cfg_q.s38   <= cfg_data_i[GAIN_W-1:0];
        REG_C38:   cfg_q.c38   <= cfg_data_i[GAIN_W-1:0];
        REG_S76:   cfg_q.s76   <= cfg_data_i[GAIN_W-1:0];
        default:   cfg_q <= cfg_q;
      endcase
    end
  end

  // Request intake and phase tagging.
  qfmx_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .smp_i  (smp),
    .step_i (cfg_q.step),
    .pop_i  (inq_pop),
    .empty_o(inq_empty),
    .head_o (head)
  );

  // Processing engine.
  qfmx_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .inq_empty_i(inq_empty),
    .head_i     (head),
    .inq_pop_o  (inq_pop),
    .outq_full_i(outq_full),
    .outq_push_o(outq_push),
    .mpx_o      (mpx_res)
  );

  // Result queue.
  qfmx_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (outq_push),
    .data_i (mpx_res),
    .full_o (outq_full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (mpx_out)
  );

endmodule

>>> design/qfmx_checker.sv
// Port-level checks for the encoder top level and the bind that attaches them.
// Depends on qfmx_pkg and quadraphonic_fm_multiplex_encoder_core.
module qfmx_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             push,
  input logic                             full,
  input logic                             pop,
  input logic                             empty,
  input logic [qfmx_pkg::SAMPLE_BITS-1:0] mpx_sample_o
);
  import qfmx_pkg::*;

  // Both queues come out of reset empty.
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> (empty && !full))
    else $error("queues not empty after reset");

  // The input side only fills up through an accepted request.
  a_full_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push && !full))
    else $error("full rose without an accepted request");

  // The result side only drains through an accepted pop.
  a_empty_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(empty) |-> $past(pop && !empty))
    else $error("result vanished without a pop");

  // A waiting result holds until it is taken.
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(mpx_sample_o)))
    else $error("waiting result changed");

endmodule

bind quadraphonic_fm_multiplex_encoder_core qfmx_checker u_qfmx_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .push        (push),
  .full        (full),
  .pop         (pop),
  .empty       (empty),
  .mpx_sample_o(mpx_sample_o)
);
